// File: rtl/core/i2rd_pkg.sv
// shared types, constants and the digit alphabet for the radix digit converter
package i2rd_pkg;

  localparam int unsigned VALUE_W        = 63;
  localparam int unsigned RADIX_W        = 7;
  localparam int unsigned DIGIT_W        = 6;
  localparam int unsigned CHAR_W         = 7;
  localparam int unsigned MAX_DIGITS_DEF = 64;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 7'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 7'd64;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 7'd10;

  // register byte addresses
  localparam logic [2:0] ADDR_RADIX      = 3'd0;
  localparam logic [2:0] ADDR_MIN_DIGITS = 3'd4;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [RADIX_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [DIGIT_W-1:0] remainder;
  } div_rsp_t;

  // 0-9, A-Z, a-z, then '-' and '_'
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    logic [CHAR_W-1:0] ch;
    dx = {1'b0, d};
    if (dx < 7'd10) begin
      ch = 7'h30 + dx;
    end else if (dx < 7'd36) begin
      ch = 7'h41 + (dx - 7'd10);
    end else if (dx < 7'd62) begin
      ch = 7'h61 + (dx - 7'd36);
    end else if (dx == 7'd62) begin
      ch = 7'h2d;
    end else begin
      ch = 7'h5f;
    end
    return ch;
  endfunction

endpackage

// File: rtl/core/i2rd_div.sv
// iterative restoring divider, one quotient bit per cycle, small divisor
module i2rd_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  i2rd_pkg::div_req_t  req_i,
  output i2rd_pkg::div_rsp_t  rsp_o
);
  import i2rd_pkg::*;

  localparam int unsigned CNT_W = $clog2(VALUE_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [VALUE_W-1:0] dvd_q, dvd_d;
  logic [RADIX_W-1:0] rem_q, rem_d;
  logic [RADIX_W-1:0] dsr_q, dsr_d;
  logic [RADIX_W:0]   trial;
  logic               ge;

  assign trial = {rem_q, dvd_q[VALUE_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (busy_q) begin
      dvd_d = {dvd_q[VALUE_W-2:0], ge};
      rem_d = ge ? RADIX_W'(trial - {1'b0, dsr_q}) : trial[RADIX_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dvd_q;
  assign rsp_o.remainder = rem_q[DIGIT_W-1:0];

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < dsr_q))
    else $error("divider remainder not below divisor");

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.start)
    else $error("divider started while busy");

endmodule

// File: rtl/core/integer_to_radix_digits_core.sv
// radix conversion core: repeated division into a digit store, zero padding, then digit streaming
// steps: each digit is produced by the divider between the check and divide states,
// zero padding digits are then written up to the minimum length, and the digits are
// emitted most significant first through the read, load and hold states
// one request at a time; the shared bit-serial divider and the output handshake set the rate
// reset: asynchronous, radix 10, minimum length 0, idle and ready for a request
module integer_to_radix_digits_core #(
  parameter int unsigned MAX_DIGITS = i2rd_pkg::MAX_DIGITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // value [62:0]
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // digit_value [5:0], digit_char [12:6]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import i2rd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned AW = $clog2(MAX_DIGITS);
  localparam logic [CW-1:0]      N_MAX   = CW'(MAX_DIGITS);
  localparam logic [RADIX_W-1:0] MAX_R7  = RADIX_W'(MAX_DIGITS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_PAD  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_LD   = 3'd5;
  localparam logic [2:0] S_HOLD = 3'd6;

  logic [RADIX_W-1:0] radix_q, min_digits_q;
  logic               cfg_we;

  logic [2:0]         state_q, state_d;
  logic [VALUE_W-1:0] quot_q, quot_d;
  logic [CW-1:0]      n_q, n_d;
  logic [CW-1:0]      minlen_q, minlen_d;
  logic [RADIX_W-1:0] base_q, base_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  logic               out_last_q, out_last_d;
  logic [DIGIT_W-1:0] out_digit_q, out_digit_d;
  logic [CHAR_W-1:0]  out_char_q, out_char_d;

  logic [RADIX_W-1:0] eff_radix;
  logic [RADIX_W-1:0] eff_min;
  logic [CW-1:0]      n_dec;

  logic               mem_we;
  logic [DIGIT_W-1:0] mem_wdata;
  logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];
  logic [DIGIT_W-1:0] rdata_q;

  logic     div_start;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // configuration
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == ADDR_MIN_DIGITS[2]) ? {25'd0, min_digits_q}
                                                   : {25'd0, radix_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q      <= RADIX_RESET;
      min_digits_q <= '0;
    end else if (cfg_we) begin
      if (paddr[2] == ADDR_RADIX[2]) begin
        radix_q <= pwdata[RADIX_W-1:0];
      end else begin
        min_digits_q <= pwdata[RADIX_W-1:0];
      end
    end
  end

  assign eff_radix = (radix_q < RADIX_MIN) ? RADIX_MIN :
                     (radix_q > RADIX_MAX) ? RADIX_MAX : radix_q;
  assign eff_min   = (min_digits_q > MAX_R7) ? MAX_R7 : min_digits_q;
  assign n_dec     = n_q - 1'b1;

  i2rd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign div_req.start    = div_start;
  assign div_req.dividend = quot_q;
  assign div_req.divisor  = base_q;

  always_comb begin
    state_d       = state_q;
    quot_d        = quot_q;
    n_d           = n_q;
    minlen_d      = minlen_q;
    base_d        = base_q;
    idx_d         = idx_q;
    out_valid_d   = out_valid_q;
    out_last_d    = out_last_q;
    out_digit_d   = out_digit_q;
    out_char_d    = out_char_q;
    mem_we        = 1'b0;
    mem_wdata     = '0;
    div_start     = 1'b0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          quot_d   = s_axis_tdata[VALUE_W-1:0];
          n_d      = '0;
          base_d   = eff_radix;
          minlen_d = CW'(eff_min);
          state_d  = S_CHK;
        end
      end
      S_CHK: begin
        if (quot_q != '0 && n_q != N_MAX) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          state_d = S_PAD;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          mem_we    = 1'b1;
          mem_wdata = div_rsp.remainder;
          quot_d    = div_rsp.quotient;
          n_d       = n_q + 1'b1;
          state_d   = S_CHK;
        end
      end
      S_PAD: begin
        if (n_q < minlen_q) begin
          mem_we = 1'b1;
          n_d    = n_q + 1'b1;
        end else if (n_q == '0) begin
          state_d = S_IDLE;
        end else begin
          idx_d   = n_dec[AW-1:0];
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_LD;
      end
      S_LD: begin
        out_digit_d = rdata_q;
        out_char_d  = digit_to_char(rdata_q);
        out_last_d  = (idx_q == '0);
        out_valid_d = 1'b1;
        state_d     = S_HOLD;
      end
      S_HOLD: begin
        if (m_axis_tready) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      quot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      quot_q      <= quot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    minlen_q    <= minlen_d;
    base_q      <= base_d;
    idx_q       <= idx_d;
    out_last_q  <= out_last_d;
    out_digit_q <= out_digit_d;
    out_char_q  <= out_char_d;
  end

  // digit store, least significant digit at address 0
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem[n_q[AW-1:0]] <= mem_wdata;
    end
    rdata_q <= digit_mem[idx_q];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {3'b000, out_char_q, out_digit_q};

  a_valid_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (state_q == S_HOLD))
    else $error("output valid outside the hold state");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= N_MAX)
    else $error("digit count above store size");

  a_digit_below_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_rsp.done && state_q == S_DIV) |-> ({1'b0, div_rsp.remainder} < base_q))
    else $error("digit not below radix");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (n_q < N_MAX))
    else $error("digit store write beyond its size");

endmodule
